// ===== sv/dmwc_pkg.sv =====
package dmwc_pkg;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_WB,
    ST_FILL
  } state_t;

  localparam int unsigned DATA_W = 32;

endpackage

// ===== sv/dmwc_req_if.sv =====
interface dmwc_req_if #(
  parameter int ADDR_BITS = 20
);
  logic                 valid;
  logic                 ready;
  logic                 mode;
  logic [ADDR_BITS-1:0] address;
  logic [31:0]          store_data;

  modport source (output valid, mode, address, store_data, input ready);
  modport sink   (input valid, mode, address, store_data, output ready);
endinterface

// ===== sv/dmwc_rsp_if.sv =====
interface dmwc_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        was_hit;
  logic [31:0] hits_so_far;
  logic [31:0] misses_so_far;

  modport source (output valid, read_data, was_hit, hits_so_far, misses_so_far, input ready);
  modport sink   (input valid, read_data, was_hit, hits_so_far, misses_so_far, output ready);
endinterface

// ===== sv/dmwc_ram.sv =====
module dmwc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/direct_mapped_writeback_cache_core.sv =====
// Direct-mapped write-back cache with a second-chance used bit, in front of
// an on-chip backing memory. Tags and line state live in one RAM, line words
// in a second and the backing store in a third, all with registered reads.
// After reset the block sweeps the backing memory to zero, one word a cycle,
// all 2^(ADDR_BITS-2) words (262144 by default), and takes no request until
// that is done. One access is worked at a time: a hit, or a miss that only
// clears the used bit, finishes in the lookup; other misses fill the line
// from the backing memory, first writing a dirty old line back. A finished
// response waits in an output register, and no new request is taken while
// it is held and not yet accepted.
module direct_mapped_writeback_cache_core #(
  parameter int LINES          = 256,
  parameter int WORDS_PER_LINE = 16,
  parameter int ADDR_BITS      = 20
) (
  input  logic      clk,
  input  logic      rst,
  dmwc_req_if.sink   req,
  dmwc_rsp_if.source rsp
);
  import dmwc_pkg::*;

  localparam int WB = $clog2(WORDS_PER_LINE);
  localparam int LB = $clog2(LINES);
  localparam int MB = ADDR_BITS - 2;
  localparam int TB = MB - WB - LB;
  localparam int MW = TB + 3;
  localparam int CB = WB + 1;
  localparam logic [CB-1:0] CNT_LAST = CB'(WORDS_PER_LINE);

  state_t state, state_next;
  logic [CB-1:0]     cnt;
  logic [CB-1:0]     cnt_m1;
  logic [MB-1:0]     clr_idx;
  logic              mode_q;
  logic [MB-1:0]     addr_q;
  logic [DATA_W-1:0] data_q;
  logic [TB-1:0]     old_tag;
  logic [DATA_W-1:0] rd_q;
  logic              hit_q;
  logic [31:0]       hit_count;
  logic [31:0]       miss_count;

  logic [WB-1:0] a_word;
  logic [LB-1:0] a_line;
  logic [TB-1:0] a_tag;

  logic          meta_we;
  logic [LB-1:0] meta_waddr;
  logic [MW-1:0] meta_wdata;
  logic [LB-1:0] meta_raddr;
  logic [MW-1:0] meta_q;

  logic             line_we;
  logic [WB+LB-1:0] line_waddr;
  logic [DATA_W-1:0] line_wdata;
  logic [WB+LB-1:0] line_raddr;
  logic [DATA_W-1:0] line_q;

  logic              mem_we;
  logic [MB-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic [MB-1:0]     mem_raddr;
  logic [DATA_W-1:0] mem_q;

  logic          m_valid, m_dirty, m_used, is_hit, accept, done;
  logic [TB-1:0] m_tag;
  logic [DATA_W-1:0] rd_now;

  assign a_word  = addr_q[WB-1:0];
  assign a_line  = addr_q[WB +: LB];
  assign a_tag   = addr_q[MB-1 -: TB];
  assign m_valid = meta_q[MW-1];
  assign m_dirty = meta_q[MW-2];
  assign m_used  = meta_q[MW-3];
  assign m_tag   = meta_q[TB-1:0];
  assign is_hit  = m_valid && (m_tag == a_tag);
  assign cnt_m1  = cnt - CB'(1);
  assign rd_now  = mode_q ? '0 : (is_hit ? line_q : mem_q);

  assign req.ready = (state == ST_IDLE) && (!rsp.valid || rsp.ready);
  assign accept    = req.valid && req.ready;
  assign done      = ((state == ST_LOOKUP) && (is_hit || (m_valid && m_used))) ||
                     ((state == ST_FILL) && (cnt == CNT_LAST));

  dmwc_ram #(.WIDTH(MW), .DEPTH(LINES)) u_meta (
    .clk, .we(meta_we), .waddr(meta_waddr), .wdata(meta_wdata),
    .raddr(meta_raddr), .rdata(meta_q)
  );

  dmwc_ram #(.WIDTH(DATA_W), .DEPTH(LINES * WORDS_PER_LINE)) u_line (
    .clk, .we(line_we), .waddr(line_waddr), .wdata(line_wdata),
    .raddr(line_raddr), .rdata(line_q)
  );

  dmwc_ram #(.WIDTH(DATA_W), .DEPTH(2 ** MB)) u_mem (
    .clk, .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_q)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (&clr_idx) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) state_next = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        if (is_hit || (m_valid && m_used)) state_next = ST_IDLE;
        else if (m_valid && m_dirty)       state_next = ST_WB;
        else                               state_next = ST_FILL;
      end
      ST_WB: begin
        if (cnt == CNT_LAST) state_next = ST_FILL;
      end
      ST_FILL: begin
        if (cnt == CNT_LAST) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    meta_we    = 1'b0;
    meta_waddr = a_line;
    meta_wdata = '0;
    meta_raddr = req.address[2 + WB +: LB];
    line_we    = 1'b0;
    line_waddr = {a_line, a_word};
    line_wdata = data_q;
    line_raddr = req.address[2 +: WB + LB];
    mem_we     = 1'b0;
    mem_waddr  = addr_q;
    mem_wdata  = data_q;
    mem_raddr  = req.address[ADDR_BITS-1:2];
    case (state)
      ST_CLEAR: begin
        mem_we     = 1'b1;
        mem_waddr  = clr_idx;
        mem_wdata  = '0;
        meta_we    = (clr_idx[MB-1:LB] == '0);
        meta_waddr = clr_idx[LB-1:0];
      end
      ST_LOOKUP: begin
        meta_we = 1'b1;
        if (is_hit) begin
          meta_wdata = {1'b1, m_dirty | mode_q, 1'b1, a_tag};
          line_we    = mode_q;
        end else begin
          mem_we = mode_q;
          if (m_valid && m_used) meta_wdata = {1'b1, m_dirty, 1'b0, m_tag};
          else                   meta_wdata = {1'b1, 1'b0, 1'b0, a_tag};
        end
      end
      ST_WB: begin
        line_raddr = {a_line, cnt[WB-1:0]};
        mem_we     = (cnt != '0);
        mem_waddr  = {old_tag, a_line, cnt_m1[WB-1:0]};
        mem_wdata  = line_q;
      end
      ST_FILL: begin
        mem_raddr  = {a_tag, a_line, cnt[WB-1:0]};
        line_we    = (cnt != '0);
        line_waddr = {a_line, cnt_m1[WB-1:0]};
        line_wdata = mem_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      cnt        <= '0;
      clr_idx    <= '0;
      hit_count  <= '0;
      miss_count <= '0;
      rsp.valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state != state_next) cnt <= '0;
      else if (state == ST_WB || state == ST_FILL) cnt <= cnt + CB'(1);
      if (state == ST_CLEAR) clr_idx <= clr_idx + MB'(1);
      if (state == ST_LOOKUP) begin
        if (is_hit) hit_count  <= hit_count + 32'd1;
        else        miss_count <= miss_count + 32'd1;
      end
      if (done)           rsp.valid <= 1'b1;
      else if (rsp.ready) rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q <= req.mode;
      addr_q <= req.address[ADDR_BITS-1:2];
      data_q <= req.store_data;
    end
    if (state == ST_LOOKUP) begin
      old_tag <= m_tag;
      rd_q    <= rd_now;
      hit_q   <= is_hit;
    end
    if (done) begin
      if (state == ST_LOOKUP) begin
        rsp.read_data     <= rd_now;
        rsp.was_hit       <= is_hit;
        rsp.hits_so_far   <= is_hit ? hit_count + 32'd1 : hit_count;
        rsp.misses_so_far <= is_hit ? miss_count : miss_count + 32'd1;
      end else begin
        rsp.read_data     <= rd_q;
        rsp.was_hit       <= hit_q;
        rsp.hits_so_far   <= hit_count;
        rsp.misses_so_far <= miss_count;
      end
    end
  end

`ifndef SYNTHESIS
  a_done_free: assert property (@(posedge clk) disable iff (rst)
    done |-> (!rsp.valid || rsp.ready))
    else $error("response finished while output register is held");
  a_one_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOOKUP) |=>
      (32'(hit_count + miss_count) == 32'($past(hit_count) + $past(miss_count) + 32'd1)))
    else $error("lookup did not bump exactly one counter");
  a_wb_tag: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WB) |-> (old_tag != a_tag))
    else $error("write-back of a line with the requested tag");
`endif

endmodule

// ===== test/direct_mapped_writeback_cache_core_test.sv =====
`timescale 1ns / 1ps

module direct_mapped_writeback_cache_core_test;
  import dmwc_pkg::*;

  localparam int NLINES = 256;
  localparam int NWORDS = 16;
  localparam int MEM_DEPTH = 262144;
  localparam int STALL_LIMIT = 1000000;
  localparam bit MODE_READ = 1'b0;
  localparam bit MODE_WRITE = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [19:0] address;
    logic [31:0] store_data;
  } access_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        was_hit;
    logic [31:0] hits_so_far;
    logic [31:0] misses_so_far;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  dmwc_req_if #(.ADDR_BITS(20)) req ();
  dmwc_rsp_if rsp ();

  direct_mapped_writeback_cache_core dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  always #4 clk = ~clk;

  // Shadow copy of the cache and its backing store.
  logic        sh_valid [NLINES];
  logic [5:0]  sh_tag [NLINES];
  logic        sh_dirty [NLINES];
  logic        sh_used [NLINES];
  logic [31:0] sh_words [NLINES*NWORDS];
  logic [31:0] sh_mem [MEM_DEPTH];
  logic [31:0] sh_hits;
  logic [31:0] sh_misses;

  access_t  pending_accesses[$];
  outcome_t expected_outcomes[$];
  int       errors = 0;
  int       idle_cycles = 0;
  bit       stimulus_done = 0;
  bit       hold_sender = 0;
  bit       req_fired = 0;
  int       send_gap = 0;
  int       recv_gap = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic outcome_t cache_access(access_t a);
    outcome_t o;
    logic [17:0] waddr;
    logic [3:0]  wsel;
    logic [7:0]  lsel;
    logic [5:0]  tg;
    waddr = a.address[19:2];
    wsel = waddr[3:0];
    lsel = waddr[11:4];
    tg = waddr[17:12];
    o = '0;
    if (sh_valid[lsel] && sh_tag[lsel] == tg) begin
      o.was_hit = 1'b1;
      sh_hits++;
      sh_used[lsel] = 1'b1;
      if (a.mode == MODE_WRITE) begin
        sh_words[lsel*NWORDS + wsel] = a.store_data;
        sh_dirty[lsel] = 1'b1;
      end else begin
        o.read_data = sh_words[lsel*NWORDS + wsel];
      end
    end else begin
      sh_misses++;
      if (a.mode == MODE_WRITE) sh_mem[waddr] = a.store_data;
      else o.read_data = sh_mem[waddr];
      if (sh_valid[lsel] && sh_used[lsel]) begin
        sh_used[lsel] = 1'b0;
      end else begin
        if (sh_valid[lsel] && sh_dirty[lsel])
          for (int i = 0; i < NWORDS; i++)
            sh_mem[{sh_tag[lsel], lsel, i[3:0]}] = sh_words[lsel*NWORDS + i];
        sh_valid[lsel] = 1'b1;
        sh_tag[lsel] = tg;
        sh_dirty[lsel] = 1'b0;
        sh_used[lsel] = 1'b0;
        for (int i = 0; i < NWORDS; i++)
          sh_words[lsel*NWORDS + i] = sh_mem[{tg, lsel, i[3:0]}];
      end
    end
    o.hits_so_far = sh_hits;
    o.misses_so_far = sh_misses;
    return o;
  endfunction

  function automatic void queue_access(logic m, logic [19:0] ad, logic [31:0] d);
    access_t a;
    a.mode = m;
    a.address = ad;
    a.store_data = d;
    pending_accesses.push_back(a);
  endfunction

  // Remembers whether the request beat was taken at the last rising edge.
  always @(posedge clk) begin
    req_fired <= req.valid && req.ready;
  end

  // Driver.
  always @(negedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else if (req.valid && !req_fired) begin
    end else if (send_gap > 0) begin
      send_gap <= send_gap - 1;
      req.valid <= 1'b0;
    end else if (pending_accesses.size() > 0 && !hold_sender) begin
      access_t a;
      a = pending_accesses.pop_front();
      req.valid <= 1'b1;
      req.mode <= a.mode;
      req.address <= a.address;
      req.store_data <= a.store_data;
      send_gap <= pick_gap();
    end else begin
      req.valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= 1'b1;
      if (rsp.valid && rsp.ready) recv_gap <= pick_gap();
    end
  end

  // Monitor: predict on accepted requests, check accepted responses.
  always @(posedge clk) begin
    if (!rst) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (req.valid && req.ready) begin
        access_t a;
        a.mode = req.mode;
        a.address = req.address;
        a.store_data = req.store_data;
        expected_outcomes.push_back(cache_access(a));
      end
      if (rsp.valid && rsp.ready) begin
        outcome_t got;
        outcome_t want;
        got.read_data = rsp.read_data;
        got.was_hit = rsp.was_hit;
        got.hits_so_far = rsp.hits_so_far;
        got.misses_so_far = rsp.misses_so_far;
        if (expected_outcomes.size() == 0) begin
          $display("%0t: unexpected beat %h", $time, got);
          errors++;
        end else begin
          want = expected_outcomes.pop_front();
          if (got.read_data !== want.read_data)
            $display("%0t: read_data expected %h actual %h", $time, want.read_data,
                     got.read_data);
          if (got.was_hit !== want.was_hit)
            $display("%0t: was_hit expected %b actual %b", $time, want.was_hit,
                     got.was_hit);
          if (got.hits_so_far !== want.hits_so_far)
            $display("%0t: hits_so_far expected %0d actual %0d", $time,
                     want.hits_so_far, got.hits_so_far);
          if (got.misses_so_far !== want.misses_so_far)
            $display("%0t: misses_so_far expected %0d actual %0d", $time,
                     want.misses_so_far, got.misses_so_far);
          if (got !== want) errors++;
        end
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    logic [19:0] ad;
    logic [7:0]  hot_line;
    req.valid = 1'b0;
    req.mode = MODE_READ;
    req.address = '0;
    req.store_data = '0;
    rsp.ready = 1'b0;
    for (int i = 0; i < NLINES; i++) begin
      sh_valid[i] = 1'b0; sh_tag[i] = '0; sh_dirty[i] = 1'b0; sh_used[i] = 1'b0;
    end
    for (int i = 0; i < NLINES*NWORDS; i++) sh_words[i] = '0;
    for (int i = 0; i < MEM_DEPTH; i++) sh_mem[i] = '0;
    sh_hits = '0;
    sh_misses = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: cold miss, hit, write hit, conflict with used set, eviction
    // of a dirty line, write miss, address extremes.
    queue_access(MODE_READ, 20'h00000, 32'h0);
    queue_access(MODE_READ, 20'h00004, 32'h0);
    queue_access(MODE_WRITE, 20'h00008, 32'hffffffff);
    queue_access(MODE_READ, 20'h00008, 32'h0);
    queue_access(MODE_READ, 20'h04008, 32'h0);
    queue_access(MODE_READ, 20'h04008, 32'h0);
    queue_access(MODE_READ, 20'h00008, 32'h0);
    queue_access(MODE_WRITE, 20'h08010, 32'hdeadbeef);
    queue_access(MODE_READ, 20'h08010, 32'h0);
    queue_access(MODE_WRITE, 20'hfffff, 32'h12345678);
    queue_access(MODE_READ, 20'hffffc, 32'h0);
    queue_access(MODE_WRITE, 20'hffffd, 32'h00000001);
    queue_access(MODE_READ, 20'hffffe, 32'h0);
    queue_access(MODE_WRITE, 20'h03ffc, 32'h80000000);
    queue_access(MODE_READ, 20'h03ffc, 32'h0);
    queue_access(MODE_READ, 20'h07ffc, 32'h0);
    queue_access(MODE_READ, 20'h07ffc, 32'h0);
    queue_access(MODE_READ, 20'h03ffc, 32'h0);
    queue_access(MODE_WRITE, 20'h0000b, 32'h5a5a5a5a);
    queue_access(MODE_READ, 20'h00001, 32'h0);

    // Let the directed part drain before the random part.
    wait (pending_accesses.size() == 0);
    hold_sender = 1;
    wait (expected_outcomes.size() == 0);
    hold_sender = 0;

    // Random: mostly a few hot lines with several tags so hits, second
    // chances and dirty evictions all come up, plus full-range noise.
    for (int n = 0; n < 1330; n++) begin
      if ($urandom_range(0, 9) < 8) begin
        hot_line = 8'($urandom_range(0, 7) * 37);
        ad = {$urandom_range(0, 2) == 0 ? 6'h3f : 6'($urandom_range(0, 3)), hot_line,
              4'($urandom), 2'($urandom)};
      end else begin
        ad = 20'($urandom);
      end
      queue_access(1'($urandom_range(0, 1)), ad, $urandom);
    end

    wait (pending_accesses.size() == 0);
    wait (expected_outcomes.size() == 0);
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
